@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define MLC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// same-cycle implication
`define MLC_ASSERT_IMPL(label, cond, expr) \
    `MLC_ASSERT(label, (cond) |-> (expr))

// next-cycle implication
`define MLC_ASSERT_NEXT(label, cond, expr) \
    `MLC_ASSERT(label, (cond) |=> (expr))

`endif

@@ rtl/core/mlc_pkg.sv @@
// types, register indexes and reset values of the motion light controller
`default_nettype none

package mlc_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int REG_WIDTH           = 16;
    localparam int LIGHT_BITS          = 3;
    localparam int AMBIENT_WIDTH       = 17;
    localparam int CFG_INDEX_WIDTH     = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DARK_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MANUAL_LIGHTS   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AUTO_ENABLES    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FOYER_HOLD      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SECURITY_HOLD   = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PULSE_TICKS     = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COOLDOWN_TICKS  = 3'd6;

    localparam logic [REG_WIDTH-1:0]  RST_DARK_THRESHOLD = 16'd120;
    localparam logic [LIGHT_BITS-1:0] RST_MANUAL_LIGHTS  = 3'd0;
    localparam logic [LIGHT_BITS-1:0] RST_AUTO_ENABLES   = 3'd7;
    localparam logic [REG_WIDTH-1:0]  RST_FOYER_HOLD     = 16'd200;
    localparam logic [REG_WIDTH-1:0]  RST_SECURITY_HOLD  = 16'd200;
    localparam logic [REG_WIDTH-1:0]  RST_PULSE_TICKS    = 16'd3;
    localparam logic [REG_WIDTH-1:0]  RST_COOLDOWN_TICKS = 16'd30;

    // bit positions in manual_lights and auto_enables
    localparam int LIGHT_PORCH    = 0;
    localparam int LIGHT_FOYER    = 1;
    localparam int LIGHT_SECURITY = 2;

    typedef struct packed {
        logic signed [AMBIENT_WIDTH-1:0] ambient_level;
        logic                            motion_outside;
        logic                            motion_inside;
    } tick_t;

    typedef struct packed {
        logic porch_light;
        logic foyer_light;
        logic security_light;
        logic camera_trigger;
        logic is_dark;
    } drive_t;

endpackage

`default_nettype wire

@@ rtl/core/mlc_stream_if.sv @@
// valid/ready channel carrying one payload beat
`default_nettype none

interface mlc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/motion_light_controller_top.sv @@
// motion light controller: darkness, hold timers, camera pulse, light drives
//
//   channel   | dir | payload          | beat
//   ----------+-----+------------------+-----------------------------------
//   tick_ch   | in  | mlc_pkg::tick_t  | one control tick
//   drive_ch  | out | mlc_pkg::drive_t | one light/camera result per tick
//   cfg_*     | in  | index + 16b data | register write, no read-back
//
// one tick per cycle unless the result stalls; path: input register, result register
// the hold, pulse and cooldown counters update as a tick moves into the result register,
// so the next tick sees the updated values
// reset clears config to defaults and all counters to zero
// a stalled result holds; the input register keeps taking beats while it has room
`default_nettype none
`include "assert_macros.svh"

module motion_light_controller_top #(
    parameter int COUNT_WIDTH = mlc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wen,
    input  wire logic [mlc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [mlc_pkg::REG_WIDTH-1:0]        cfg_data,
    mlc_stream_if.sink                                tick_ch,
    mlc_stream_if.source                              drive_ch
);

    // configuration
    logic [mlc_pkg::REG_WIDTH-1:0]  dark_threshold_reg;
    logic [mlc_pkg::LIGHT_BITS-1:0] manual_lights_reg;
    logic [mlc_pkg::LIGHT_BITS-1:0] auto_enables_reg;
    logic [mlc_pkg::REG_WIDTH-1:0]  foyer_hold_ticks_reg;
    logic [mlc_pkg::REG_WIDTH-1:0]  security_hold_ticks_reg;
    logic [mlc_pkg::REG_WIDTH-1:0]  pulse_ticks_reg;
    logic [mlc_pkg::REG_WIDTH-1:0]  cooldown_ticks_reg;

    // tick state
    logic                   prev_outside_reg, prev_outside_next;
    logic [COUNT_WIDTH-1:0] foyer_left_reg, foyer_left_next;
    logic [COUNT_WIDTH-1:0] security_left_reg, security_left_next;
    logic                   pulse_active_reg, pulse_active_next;
    logic [COUNT_WIDTH-1:0] pulse_left_reg, pulse_left_next;
    logic [COUNT_WIDTH-1:0] cooldown_left_reg, cooldown_left_next;

    // pipeline
    logic            s1_valid_reg, s1_valid_next;
    mlc_pkg::tick_t  s1_data_reg;
    logic            out_valid_reg, out_valid_next;
    mlc_pkg::drive_t out_data_reg, out_data_next;

    logic out_free;
    logic s1_move;
    logic tick_accept;

    // per-tick combinational values
    logic                   dark;
    logic                   porch_en, foyer_en, sec_auto;
    logic                   mo, mi;
    logic                   rising;
    logic                   pulse_start;
    logic                   pulse_now;
    logic [COUNT_WIDTH-1:0] foyer_now, security_now, pulse_left_now, cooldown_now;

    function automatic logic [COUNT_WIDTH-1:0] clamp_count(
        input logic [mlc_pkg::REG_WIDTH-1:0] v
    );
        logic [31:0] wide;
        wide = 32'(v);
        if ((wide >> COUNT_WIDTH) != 32'd0) begin
            return '1;
        end
        return COUNT_WIDTH'(v);
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] count_down(
        input logic [COUNT_WIDTH-1:0] v
    );
        return (v != '0) ? (v - COUNT_WIDTH'(1)) : '0;
    endfunction

    // handshake
    assign out_free       = !out_valid_reg || drive_ch.ready;
    assign s1_move        = s1_valid_reg && out_free;
    assign tick_ch.ready  = !s1_valid_reg || out_free;
    assign tick_accept    = tick_ch.valid && tick_ch.ready;
    assign drive_ch.valid = out_valid_reg;
    assign drive_ch.data  = out_data_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (tick_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_move) begin
            out_valid_next = 1'b1;
        end else if (drive_ch.ready) begin
            out_valid_next = 1'b0;
        end
    end

    // tick evaluation
    always_comb
    begin
        mo       = s1_data_reg.motion_outside;
        mi       = s1_data_reg.motion_inside;
        porch_en = auto_enables_reg[mlc_pkg::LIGHT_PORCH];
        foyer_en = auto_enables_reg[mlc_pkg::LIGHT_FOYER];
        sec_auto = auto_enables_reg[mlc_pkg::LIGHT_SECURITY];

        // a failed read (negative) is never dark
        dark = !s1_data_reg.ambient_level[mlc_pkg::AMBIENT_WIDTH-1]
            && (s1_data_reg.ambient_level[mlc_pkg::REG_WIDTH-1:0] <= dark_threshold_reg);

        foyer_now = (foyer_en && mi) ? clamp_count(foyer_hold_ticks_reg)
                                     : foyer_left_reg;
        security_now = (sec_auto && mo && dark) ? clamp_count(security_hold_ticks_reg)
                                                : security_left_reg;

        rising      = mo && !prev_outside_reg;
        pulse_start = sec_auto && rising && !pulse_active_reg && (cooldown_left_reg == '0);

        pulse_now      = pulse_active_reg;
        pulse_left_now = pulse_left_reg;
        cooldown_now   = cooldown_left_reg;
        if (pulse_start) begin
            pulse_now      = 1'b1;
            pulse_left_now = clamp_count(pulse_ticks_reg);
            cooldown_now   = clamp_count(cooldown_ticks_reg);
        end
        // a zero-length pulse ends in the tick it starts
        if (pulse_now && (pulse_left_now == '0)) begin
            pulse_now = 1'b0;
        end
        if (!sec_auto) begin
            pulse_now = 1'b0;
        end

        out_data_next.porch_light = manual_lights_reg[mlc_pkg::LIGHT_PORCH]
            || (porch_en && dark);
        out_data_next.foyer_light = manual_lights_reg[mlc_pkg::LIGHT_FOYER]
            || (foyer_en && (foyer_now != '0));
        out_data_next.security_light = manual_lights_reg[mlc_pkg::LIGHT_SECURITY]
            || (sec_auto && (security_now != '0));
        out_data_next.camera_trigger = pulse_now;
        out_data_next.is_dark        = dark;

        prev_outside_next  = mo;
        foyer_left_next    = count_down(foyer_now);
        security_left_next = count_down(security_now);
        pulse_active_next  = pulse_now;
        pulse_left_next    = count_down(pulse_left_now);
        cooldown_left_next = count_down(cooldown_now);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            prev_outside_reg  <= 1'b0;
            foyer_left_reg    <= '0;
            security_left_reg <= '0;
            pulse_active_reg  <= 1'b0;
            pulse_left_reg    <= '0;
            cooldown_left_reg <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_move) begin
                prev_outside_reg  <= prev_outside_next;
                foyer_left_reg    <= foyer_left_next;
                security_left_reg <= security_left_next;
                pulse_active_reg  <= pulse_active_next;
                pulse_left_reg    <= pulse_left_next;
                cooldown_left_reg <= cooldown_left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept) begin
            s1_data_reg <= tick_ch.data;
        end
        if (s1_move) begin
            out_data_reg <= out_data_next;
        end
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dark_threshold_reg      <= mlc_pkg::RST_DARK_THRESHOLD;
            manual_lights_reg       <= mlc_pkg::RST_MANUAL_LIGHTS;
            auto_enables_reg        <= mlc_pkg::RST_AUTO_ENABLES;
            foyer_hold_ticks_reg    <= mlc_pkg::RST_FOYER_HOLD;
            security_hold_ticks_reg <= mlc_pkg::RST_SECURITY_HOLD;
            pulse_ticks_reg         <= mlc_pkg::RST_PULSE_TICKS;
            cooldown_ticks_reg      <= mlc_pkg::RST_COOLDOWN_TICKS;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                mlc_pkg::REG_DARK_THRESHOLD:
                    dark_threshold_reg <= cfg_data;
                mlc_pkg::REG_MANUAL_LIGHTS:
                    manual_lights_reg <= cfg_data[mlc_pkg::LIGHT_BITS-1:0];
                mlc_pkg::REG_AUTO_ENABLES:
                    auto_enables_reg <= cfg_data[mlc_pkg::LIGHT_BITS-1:0];
                mlc_pkg::REG_FOYER_HOLD:
                    foyer_hold_ticks_reg <= cfg_data;
                mlc_pkg::REG_SECURITY_HOLD:
                    security_hold_ticks_reg <= cfg_data;
                mlc_pkg::REG_PULSE_TICKS:
                    pulse_ticks_reg <= cfg_data;
                mlc_pkg::REG_COOLDOWN_TICKS:
                    cooldown_ticks_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // no camera pulse reaches the output while security auto is off
    `MLC_ASSERT_NEXT(a_no_pulse_sec_off,
        s1_move && !auto_enables_reg[mlc_pkg::LIGHT_SECURITY],
        !out_data_reg.camera_trigger)

    // an expired foyer hold without new motion or manual drive gives a dark foyer
    `MLC_ASSERT_NEXT(a_foyer_off_expired,
        s1_move && (foyer_left_reg == '0) && !s1_data_reg.motion_inside
            && !manual_lights_reg[mlc_pkg::LIGHT_FOYER],
        !out_data_reg.foyer_light)

    // input stalls only when both stages are full and the result is held
    `MLC_ASSERT_IMPL(a_stall_only_full,
        !tick_ch.ready,
        s1_valid_reg && out_valid_reg && !drive_ch.ready)

endmodule

`default_nettype wire

@@ verif/motion_light_controller_top_tb.sv @@
// self-checking testbench for motion_light_controller_top with its own light and camera predictor
`timescale 1ns / 1ps

module motion_light_controller_top_tb;

    localparam int CW               = mlc_pkg::COUNT_WIDTH_DEFAULT;
    localparam int RANDOM_TICKS     = 428;
    localparam int QUIET_FROM       = 360;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES    = 4;
    localparam int STALL_LIMIT      = 2000;

    // no register sits at the last index, writes there must change nothing
    localparam logic [mlc_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [mlc_pkg::REG_WIDTH-1:0]  threshold;
        logic [mlc_pkg::LIGHT_BITS-1:0] manual;
        logic [mlc_pkg::LIGHT_BITS-1:0] auto_en;
        logic [mlc_pkg::REG_WIDTH-1:0]  foyer_hold;
        logic [mlc_pkg::REG_WIDTH-1:0]  security_hold;
        logic [mlc_pkg::REG_WIDTH-1:0]  pulse_len;
        logic [mlc_pkg::REG_WIDTH-1:0]  cooldown;
    } light_settings_t;

    class drive_scoreboard;
        light_settings_t settings;
        bit              prev_outside;
        logic [CW-1:0]   foyer_left;
        logic [CW-1:0]   security_left;
        bit              pulse_on;
        logic [CW-1:0]   pulse_left;
        logic [CW-1:0]   cooldown_left;
        mlc_pkg::drive_t expected_drives[$];
        int              mismatch_count;

        function new();
            settings.threshold     = mlc_pkg::RST_DARK_THRESHOLD;
            settings.manual        = mlc_pkg::RST_MANUAL_LIGHTS;
            settings.auto_en       = mlc_pkg::RST_AUTO_ENABLES;
            settings.foyer_hold    = mlc_pkg::RST_FOYER_HOLD;
            settings.security_hold = mlc_pkg::RST_SECURITY_HOLD;
            settings.pulse_len     = mlc_pkg::RST_PULSE_TICKS;
            settings.cooldown      = mlc_pkg::RST_COOLDOWN_TICKS;
            prev_outside   = 1'b0;
            foyer_left     = '0;
            security_left  = '0;
            pulse_on       = 1'b0;
            pulse_left     = '0;
            cooldown_left  = '0;
            mismatch_count = 0;
        endfunction

        function void set_register(logic [mlc_pkg::CFG_INDEX_WIDTH-1:0] index,
                                   logic [mlc_pkg::REG_WIDTH-1:0] value);
            case (index)
                mlc_pkg::REG_DARK_THRESHOLD: settings.threshold     = value;
                mlc_pkg::REG_MANUAL_LIGHTS:
                    settings.manual  = value[mlc_pkg::LIGHT_BITS-1:0];
                mlc_pkg::REG_AUTO_ENABLES:
                    settings.auto_en = value[mlc_pkg::LIGHT_BITS-1:0];
                mlc_pkg::REG_FOYER_HOLD:     settings.foyer_hold    = value;
                mlc_pkg::REG_SECURITY_HOLD:  settings.security_hold = value;
                mlc_pkg::REG_PULSE_TICKS:    settings.pulse_len     = value;
                mlc_pkg::REG_COOLDOWN_TICKS: settings.cooldown      = value;
                default: ;
            endcase
        endfunction

        function void note_tick(mlc_pkg::tick_t t);
            bit              dark;
            bit              rising;
            bit              porch_en;
            bit              foyer_en;
            bit              security_en;
            mlc_pkg::drive_t d;
            // a negative reading is a failed read and never counts as dark
            dark = !t.ambient_level[mlc_pkg::AMBIENT_WIDTH-1]
                && (t.ambient_level[mlc_pkg::REG_WIDTH-1:0] <= settings.threshold);
            porch_en    = settings.auto_en[mlc_pkg::LIGHT_PORCH];
            foyer_en    = settings.auto_en[mlc_pkg::LIGHT_FOYER];
            security_en = settings.auto_en[mlc_pkg::LIGHT_SECURITY];

            if (security_en && t.motion_outside && dark)
                security_left = CW'(settings.security_hold);
            if (foyer_en && t.motion_inside)
                foyer_left = CW'(settings.foyer_hold);

            rising = t.motion_outside && !prev_outside;
            if (security_en && rising && !pulse_on && cooldown_left == 0)
            begin
                pulse_on      = 1'b1;
                pulse_left    = CW'(settings.pulse_len);
                cooldown_left = CW'(settings.cooldown);
            end
            if (pulse_on && pulse_left == 0)
                pulse_on = 1'b0;
            if (!security_en)
                pulse_on = 1'b0;

            d.porch_light    = settings.manual[mlc_pkg::LIGHT_PORCH] || (porch_en && dark);
            d.foyer_light    = settings.manual[mlc_pkg::LIGHT_FOYER]
                            || (foyer_en && foyer_left != 0);
            d.security_light = settings.manual[mlc_pkg::LIGHT_SECURITY]
                            || (security_en && security_left != 0);
            d.camera_trigger = pulse_on;
            d.is_dark        = dark;
            expected_drives.push_back(d);

            prev_outside = t.motion_outside;
            if (foyer_left != 0)    foyer_left--;
            if (security_left != 0) security_left--;
            if (pulse_left != 0)    pulse_left--;
            if (cooldown_left != 0) cooldown_left--;
        endfunction

        function void compare_field(string name, logic expected, logic actual);
            if (actual !== expected)
            begin
                $error("%s: expected %0b, got %0b", name, expected, actual);
                mismatch_count++;
            end
        endfunction

        function void check_drive(mlc_pkg::drive_t actual);
            mlc_pkg::drive_t expected;
            if (expected_drives.size() == 0)
            begin
                $error("drive beat with nothing expected: %b", actual);
                mismatch_count++;
                return;
            end
            expected = expected_drives.pop_front();
            compare_field("porch_light",    expected.porch_light,    actual.porch_light);
            compare_field("foyer_light",    expected.foyer_light,    actual.foyer_light);
            compare_field("security_light", expected.security_light, actual.security_light);
            compare_field("camera_trigger", expected.camera_trigger, actual.camera_trigger);
            compare_field("is_dark",        expected.is_dark,        actual.is_dark);
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_wen;
    logic [mlc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [mlc_pkg::REG_WIDTH-1:0]       cfg_data;

    mlc_stream_if #(.payload_t(mlc_pkg::tick_t))  tick_ch ();
    mlc_stream_if #(.payload_t(mlc_pkg::drive_t)) drive_ch ();

    motion_light_controller_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick_ch   (tick_ch),
        .drive_ch  (drive_ch)
    );

    drive_scoreboard sb = new();

    bit long_hold_req = 1'b0;
    bit quiet_end     = 1'b0;
    int tx_gap_pct    = 0;
    bit outside_level = 1'b0;
    bit inside_level  = 1'b0;
    int stall_cycles  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sink side: random stalls in windows of varying density, plus one long hold-off
    initial
    begin : receiver
        int stall_left;
        int window_left;
        int stall_pct;
        stall_left  = 0;
        window_left = 0;
        stall_pct   = 0;
        drive_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (window_left == 0)
            begin
                window_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            window_left--;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                drive_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (!quiet_end && $urandom_range(0, 99) < stall_pct)
            begin
                drive_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end
            else
                drive_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && drive_ch.valid && drive_ch.ready)
            sb.check_drive(drive_ch.data);
    end

    always @(posedge clk)
    begin
        if ((tick_ch.valid && tick_ch.ready) || (drive_ch.valid && drive_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic mlc_pkg::tick_t mk_tick(int ambient, bit outside, bit indoor);
        mlc_pkg::tick_t t;
        t.ambient_level  = mlc_pkg::AMBIENT_WIDTH'(ambient);
        t.motion_outside = outside;
        t.motion_inside  = indoor;
        return t;
    endfunction

    // motion comes as levels with runs so that rising edges and holds both show up
    function automatic mlc_pkg::tick_t random_tick();
        int ambient;
        int sel;
        if ($urandom_range(0, 3) == 0) outside_level = !outside_level;
        if ($urandom_range(0, 2) == 0) inside_level  = !inside_level;
        sel = $urandom_range(0, 99);
        if (sel < 40)
        begin
            ambient = int'(sb.settings.threshold) + $urandom_range(0, 6) - 3;
            if (ambient < 0)     ambient = 0;
            if (ambient > 65535) ambient = 65535;
        end
        else if (sel < 65)
            ambient = $urandom_range(0, 65535);
        else if (sel < 80)
            ambient = -1 - int'($urandom_range(0, 65535));
        else if (sel < 90)
            ambient = ($urandom_range(0, 1) == 0) ? 0 : 65535;
        else
            ambient = -1;
        return mk_tick(ambient, outside_level, inside_level);
    endfunction

    function automatic logic [mlc_pkg::REG_WIDTH-1:0] pick_count(int lo, int hi);
        case ($urandom_range(0, 15))
            0:       return '1;
            1:       return '0;
            default: return mlc_pkg::REG_WIDTH'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic light_settings_t random_settings();
        light_settings_t s;
        s.threshold     = ($urandom_range(0, 3) == 0)
                        ? pick_count(0, 65535)
                        : mlc_pkg::REG_WIDTH'($urandom_range(0, 65535));
        s.manual        = ($urandom_range(0, 1) == 0)
                        ? '0 : mlc_pkg::LIGHT_BITS'($urandom_range(0, 7));
        s.auto_en       = ($urandom_range(0, 1) == 0)
                        ? '1 : mlc_pkg::LIGHT_BITS'($urandom_range(0, 7));
        s.foyer_hold    = pick_count(1, 12);
        s.security_hold = pick_count(1, 12);
        s.pulse_len     = pick_count(0, 5);
        s.cooldown      = pick_count(0, 12);
        return s;
    endfunction

    task automatic write_register(logic [mlc_pkg::CFG_INDEX_WIDTH-1:0] index,
                                  logic [mlc_pkg::REG_WIDTH-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(index, value);
    endtask

    task automatic apply_settings(light_settings_t s);
        logic [mlc_pkg::CFG_INDEX_WIDTH-1:0] index[8];
        logic [mlc_pkg::REG_WIDTH-1:0]       value[8];
        index = '{mlc_pkg::REG_DARK_THRESHOLD, mlc_pkg::REG_MANUAL_LIGHTS,
                  mlc_pkg::REG_AUTO_ENABLES, mlc_pkg::REG_FOYER_HOLD,
                  mlc_pkg::REG_SECURITY_HOLD, mlc_pkg::REG_PULSE_TICKS,
                  mlc_pkg::REG_COOLDOWN_TICKS, REG_UNUSED};
        // upper bits of the narrow registers carry junk that must be dropped
        value = '{s.threshold, {13'($urandom), s.manual}, {13'($urandom), s.auto_en},
                  s.foyer_hold, s.security_hold, s.pulse_len, s.cooldown,
                  mlc_pkg::REG_WIDTH'($urandom)};
        foreach (index[i])
            write_register(index[i], value[i]);
        cfg_wen <= 1'b0;
    endtask

    task automatic send_tick(mlc_pkg::tick_t t);
        int gap;
        gap = 0;
        if (!quiet_end && $urandom_range(0, 99) < tx_gap_pct)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        sb.note_tick(t);
    endtask

    task automatic drain_ticks();
        tick_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        light_settings_t s;
        int              sent;
        int              phase;
        int              phase_len;
        rst_n         <= 1'b0;
        cfg_wen       <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        tick_ch.valid <= 1'b0;
        tick_ch.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: threshold edge, failed reads, pulse with cooldown retrigger
        tx_gap_pct = 20;
        send_tick(mk_tick(120, 1'b0, 1'b0));
        send_tick(mk_tick(121, 1'b0, 1'b0));
        send_tick(mk_tick(0, 1'b0, 1'b1));
        send_tick(mk_tick(65535, 1'b1, 1'b0));
        send_tick(mk_tick(-1, 1'b1, 1'b0));
        send_tick(mk_tick(-65536, 1'b0, 1'b0));
        send_tick(mk_tick(100, 1'b1, 1'b1));
        send_tick(mk_tick(100, 1'b1, 1'b0));
        send_tick(mk_tick(100, 1'b0, 1'b0));
        send_tick(mk_tick(100, 1'b1, 1'b0));
        drain_ticks();

        // low extremes: zero pulse, zero cooldown, zero foyer hold, one-tick security hold
        s = '{threshold: '0, manual: '0, auto_en: '1, foyer_hold: '0, security_hold: 16'd1,
              pulse_len: '0, cooldown: '0};
        apply_settings(s);
        send_tick(mk_tick(0, 1'b1, 1'b1));
        send_tick(mk_tick(0, 1'b0, 1'b0));
        send_tick(mk_tick(0, 1'b1, 1'b0));
        send_tick(mk_tick(1, 1'b0, 1'b1));
        send_tick(mk_tick(0, 1'b1, 1'b1));
        send_tick(mk_tick(-1, 1'b0, 1'b0));
        drain_ticks();

        // high extremes: everything on, long pulse left running
        s = '{threshold: '1, manual: '1, auto_en: '1, foyer_hold: '1, security_hold: '1,
              pulse_len: '1, cooldown: '1};
        apply_settings(s);
        send_tick(mk_tick(65535, 1'b1, 1'b1));
        send_tick(mk_tick(65535, 1'b0, 1'b0));
        send_tick(mk_tick(-1, 1'b1, 1'b0));
        send_tick(mk_tick(65535, 1'b1, 1'b0));
        drain_ticks();

        // security auto off clears the running pulse, manual lights off
        s.manual  = '0;
        s.auto_en = 3'b011;
        apply_settings(s);
        send_tick(mk_tick(5, 1'b0, 1'b0));
        send_tick(mk_tick(5, 1'b1, 1'b1));
        drain_ticks();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_TICKS)
        begin
            apply_settings(random_settings());
            phase_len = $urandom_range(30, 70);
            if (phase_len > RANDOM_TICKS - sent)
                phase_len = RANDOM_TICKS - sent;
            case ($urandom_range(0, 2))
                0:       tx_gap_pct = 0;
                1:       tx_gap_pct = 15;
                default: tx_gap_pct = 40;
            endcase
            if (phase == 1)
            begin
                // sink holds off while ticks keep coming so the input side backs up
                tx_gap_pct    = 0;
                long_hold_req = 1'b1;
            end
            repeat (phase_len)
            begin
                if (sent >= QUIET_FROM)
                    quiet_end = 1'b1;
                send_tick(random_tick());
                sent++;
            end
            drain_ticks();
            phase++;
        end

        repeat (SETTLE_CYCLES * 4) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
